### sv/spq_pkg.sv
// Shared types and codes for the stable priority queue.
package spq_pkg;

    localparam int VAL_W = 32;
    localparam int CNT_W = 5;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] removed_value;
        logic                    found;
        logic signed [VAL_W-1:0] head_value;
        logic [CNT_W-1:0]        entry_count;
        logic [1:0]              status;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic start_insert;
        logic start_remove;
        logic start_search;
        logic set_full;
        logic set_empty;
        logic rd_prev;
        logic ins_shift;
        logic ins_put;
        logic rem_shift;
        logic rem_fin;
        logic idx_inc;
        logic set_found;
        logic publish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       empty;
        logic       idx_zero;
        logic       idx_at_count;
        logic       rd_greater;
        logic       rd_match;
        logic       rsp_free;
    } sts_t;

endpackage

### sv/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/spq_datapath.sv
// Queue datapath: entry memory, count, head copy, walk index and result register.
module spq_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  spq_pkg::req_t req_data,
    output spq_pkg::rsp_t res_data,
    output logic          res_valid,
    input  logic          res_stall,
    input  spq_pkg::cmd_t cmd,
    output spq_pkg::sts_t sts
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = spq_pkg::VAL_W;
    localparam int NW = spq_pkg::CNT_W;

    logic [1:0]           act_reg;
    logic signed [VW-1:0] val_reg;
    logic signed [VW-1:0] pri_reg;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        count_reg, count_next;
    logic signed [VW-1:0] head_reg, head_next;
    logic signed [VW-1:0] removed_reg, removed_next;
    logic                 found_reg, found_next;
    logic [1:0]           status_reg, status_next;
    spq_pkg::rsp_t        rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic [CW-1:0]        idx_dec;
    logic [CW-1:0]        rd_idx;
    logic [CW-1:0]        wr_idx;
    logic                 ram_we;
    logic [2*VW-1:0]      ram_wdata;
    logic [2*VW-1:0]      ram_rdata;
    logic signed [VW-1:0] rd_val;
    logic signed [VW-1:0] rd_pri;
    logic [CW+NW-1:0]     count_ext;

    assign idx_dec = idx_reg - 1'b1;
    assign rd_idx  = cmd.rd_prev ? idx_dec : idx_reg;
    assign wr_idx  = cmd.rem_shift ? idx_dec : idx_reg;
    assign ram_we  = cmd.ins_shift | cmd.ins_put | cmd.rem_shift;
    assign ram_wdata = cmd.ins_put ? {val_reg, pri_reg} : ram_rdata;
    assign rd_val  = ram_rdata[2*VW-1:VW];
    assign rd_pri  = ram_rdata[VW-1:0];

    spq_ram #(
        .WIDTH (2 * VW),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign count_ext = {{NW{1'b0}}, count_reg};

    always_comb
    begin
        sts.action       = act_reg;
        sts.full         = (count_reg == CW'(CAPACITY));
        sts.empty        = (count_reg == '0);
        sts.idx_zero     = (idx_reg == '0);
        sts.idx_at_count = (idx_reg == count_reg);
        sts.rd_greater   = (rd_pri > pri_reg);
        sts.rd_match     = (rd_val == val_reg);
        sts.rsp_free     = !rsp_valid_reg || !res_stall;
    end

    always_comb
    begin
        idx_next       = idx_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        removed_next   = removed_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && res_stall;

        if (cmd.load)
        begin
            removed_next = '0;
            found_next   = 1'b0;
            status_next  = spq_pkg::STATUS_OK;
        end
        if (cmd.set_full)
        begin
            status_next = spq_pkg::STATUS_FULL;
        end
        if (cmd.set_empty)
        begin
            status_next = spq_pkg::STATUS_EMPTY;
        end
        if (cmd.start_insert)
        begin
            idx_next = count_reg;
        end
        if (cmd.start_remove)
        begin
            removed_next = head_reg;
            idx_next     = CW'(1);
        end
        if (cmd.start_search)
        begin
            idx_next = '0;
        end
        // hole moves one slot toward the head
        if (cmd.ins_shift)
        begin
            idx_next = idx_dec;
        end
        if (cmd.ins_put)
        begin
            count_next = count_reg + 1'b1;
            if (idx_reg == '0)
            begin
                head_next = val_reg;
            end
        end
        if (cmd.rem_shift)
        begin
            if (idx_reg == CW'(1))
            begin
                head_next = rd_val;
            end
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.rem_fin)
        begin
            count_next = count_reg - 1'b1;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.set_found)
        begin
            found_next = 1'b1;
        end
        if (cmd.publish)
        begin
            rsp_next.removed_value = removed_reg;
            rsp_next.found         = found_reg;
            rsp_next.head_value    = (count_reg != '0) ? head_reg : '0;
            rsp_next.entry_count   = count_ext[NW-1:0];
            rsp_next.status        = status_reg;
            rsp_valid_next         = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= req_data.action;
            val_reg <= req_data.value;
            pri_reg <= req_data.priority_req;
        end
        head_reg    <= head_next;
        removed_reg <= removed_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        rsp_reg     <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign res_data  = rsp_reg;
    assign res_valid = rsp_valid_reg;

endmodule

### sv/spq_ctrl.sv
// Queue controller: sequences insert, remove and search walks over the entry memory.
module spq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spq_pkg::sts_t sts,
    output spq_pkg::cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DISPATCH = 9'b000000010,
        ST_INS_RD   = 9'b000000100,
        ST_INS_CMP  = 9'b000001000,
        ST_REM_RD   = 9'b000010000,
        ST_REM_WR   = 9'b000100000,
        ST_SRC_RD   = 9'b001000000,
        ST_SRC_CMP  = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (sts.action)
                    spq_pkg::ACT_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_full = 1'b1;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            cmd.start_insert = 1'b1;
                            state_next       = ST_INS_RD;
                        end
                    end
                    spq_pkg::ACT_REMOVE:
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_empty = 1'b1;
                            state_next    = ST_DONE;
                        end
                        else
                        begin
                            cmd.start_remove = 1'b1;
                            state_next       = ST_REM_RD;
                        end
                    end
                    spq_pkg::ACT_SEARCH:
                    begin
                        cmd.start_search = 1'b1;
                        state_next       = ST_SRC_RD;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            // walk from the tail: entries with a larger number slide back one slot
            ST_INS_RD:
            begin
                if (sts.idx_zero)
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (sts.rd_greater)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = ST_INS_RD;
                end
                else
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_REM_RD:
            begin
                if (sts.idx_at_count)
                begin
                    cmd.rem_fin = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_REM_WR;
                end
            end
            ST_REM_WR:
            begin
                cmd.rem_shift = 1'b1;
                state_next    = ST_REM_RD;
            end
            ST_SRC_RD:
            begin
                if (sts.idx_at_count)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SRC_CMP;
                end
            end
            ST_SRC_CMP:
            begin
                if (sts.rd_match)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SRC_RD;
                end
            end
            ST_DONE:
            begin
                if (sts.rsp_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/stable_priority_queue.sv
// Top level of the sorted, arrival-stable priority queue.
//
//  channel | valid     | stall     | payload            | direction
//  --------+-----------+-----------+--------------------+----------
//  request | req_valid | req_stall | req_data (req_t)   | in
//  result  | res_valid | res_stall | res_data (rsp_t)   | out
//
// One request at a time; every walk step is a memory read state followed by a
// compare/write state on the entry memory, which has a single read port.
// Insert slides back the entries that rank behind the new one; remove shifts every
// remaining entry one slot toward the head; search walks from the head until a
// match or the end. Full, empty and unused-code requests skip the walk.
// The next request is taken in IDLE, which follows the load of the result register,
// even while the previous result still waits; a stalled result holds the walk in DONE.
// Reset clears the count and control state; entry memory is not cleared.
module stable_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spq_pkg::req_t req_data,
    output logic          res_valid,
    input  logic          res_stall,
    output spq_pkg::rsp_t res_data
);

    spq_pkg::cmd_t cmd;
    spq_pkg::sts_t sts;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .res_data  (res_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
